>>> hw/rtl/cbd_pkg.sv
// cbd_pkg: shared types, result codes and character constants for the
// chunked body decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

    // framing characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    // body limit after reset
    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    // one result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [1:0]  error_code;
        logic [31:0] decoded_length;
    } t_result;

    // all results caused by one input word
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_result_pair;

    // decoded hex character
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h41 + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/chunked_body_decoder_unit.sv
// chunked_body_decoder_unit: de-chunks a raw body stream, one byte per word.
// Depends on cbd_pkg for result types, codes and the hex digit decoder.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one raw body byte and an
//   end-of-body flag per word. Output channel (o_out_valid / i_out_stall)
//   carries one result per word: a payload byte, a finish verdict with the
//   decoded length, or a reject verdict with an error code. o_run_end marks
//   the last result caused by one input byte. The config channel
//   (i_cfg_valid / o_cfg_ready) writes the maximum raw body size; it is
//   always ready and should be written only while the block is idle.
//   Path: an accepted byte is held in the input register, then decoded
//   into a two-entry result queue, which offers its results on the output
//   channel. Throughput: one byte per cycle while each byte gives at most
//   one result and the receiver does not stall; a byte that gives two
//   results (data byte plus early end of body) sends them one after the
//   other, paced by the single output port.
//   Reset clears the decoder to the start of a body, empties the queue and
//   sets the limit to 1048576 bytes. While the receiver stalls, results wait
//   in the queue and the input stalls once the queue holds two entries.
`timescale 1ns / 1ps
`default_nettype none

module chunked_body_decoder_unit #(
    parameter int SIZE_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input words
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_raw_byte,
    input  wire         i_end_of_body,
    // result words
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_error_code,
    output logic [31:0] o_decoded_length,
    output logic        o_run_end,
    // config write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_CR,
        PH_LF
    } t_phase;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eob;

    // config register
    logic [31:0] r_max;

    // decoder state
    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_size_accum, n_size_accum;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [32:0]          r_raw_count, n_raw_count;
    logic [31:0]          r_out_count, n_out_count;
    logic                 r_digit_seen, n_digit_seen;
    logic                 r_digits_closed, n_digits_closed;
    logic                 r_cr_pending, n_cr_pending;
    logic                 r_verdict_sent, n_verdict_sent;

    // result queue
    cbd_pkg::t_result_pair r_q [2];
    logic                  r_q_head;
    logic                  r_q_tail;
    logic [1:0]            r_q_count;
    logic                  r_q_sel;

    logic                  proc;
    logic                  in_acc;
    logic                  out_acc;
    logic                  push;
    cbd_pkg::t_result_pair n_pair;
    cbd_pkg::t_result_pair head_pair;
    cbd_pkg::t_hex         hex;

    assign proc        = r_in_valid && (r_q_count < 2'd2);
    assign o_in_stall  = r_in_valid && !proc;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign hex         = cbd_pkg::hex_digit(r_in_byte);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
        if (in_acc) begin
            r_in_byte <= i_raw_byte;
            r_in_eob  <= i_end_of_body;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= cbd_pkg::MAX_BODY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max <= i_cfg_data;
        end
    end

    // decode one byte against the current state
    always_comb begin
        n_phase         = r_phase;
        n_size_accum    = r_size_accum;
        n_bytes_left    = r_bytes_left;
        n_raw_count     = r_raw_count;
        n_out_count     = r_out_count;
        n_digit_seen    = r_digit_seen;
        n_digits_closed = r_digits_closed;
        n_cr_pending    = r_cr_pending;
        n_verdict_sent  = r_verdict_sent;
        n_pair          = '0;
        push            = 1'b0;

        if (!r_verdict_sent) begin
            if (!r_raw_count[32]) begin
                n_raw_count = r_raw_count + 33'd1;
            end
            if (n_raw_count > {1'b0, r_max}) begin
                push                       = 1'b1;
                n_pair.first.kind          = cbd_pkg::KIND_REJECT;
                n_pair.first.error_code    = cbd_pkg::ERR_TOO_LARGE;
                n_pair.first.decoded_length = r_out_count;
                n_verdict_sent             = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_SIZE: begin
                        if (r_cr_pending && r_in_byte == cbd_pkg::CH_LF) begin
                            n_cr_pending = 1'b0;
                            if (!r_digit_seen) begin
                                push                        = 1'b1;
                                n_pair.first.kind           = cbd_pkg::KIND_REJECT;
                                n_pair.first.error_code     = cbd_pkg::ERR_MALFORMED;
                                n_pair.first.decoded_length = r_out_count;
                                n_verdict_sent              = 1'b1;
                            end else if (r_size_accum == '0) begin
                                push                        = 1'b1;
                                n_pair.first.kind           = cbd_pkg::KIND_DONE;
                                n_pair.first.decoded_length = r_out_count;
                                n_verdict_sent              = 1'b1;
                            end else begin
                                n_bytes_left    = r_size_accum;
                                n_phase         = PH_DATA;
                                n_size_accum    = '0;
                                n_digit_seen    = 1'b0;
                                n_digits_closed = 1'b0;
                            end
                        end else begin
                            n_cr_pending = (r_in_byte == cbd_pkg::CH_CR);
                            if (!r_digits_closed) begin
                                if (hex.ok) begin
                                    // size would not fit in SIZE_BITS
                                    if (r_size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                                        push                    = 1'b1;
                                        n_pair.first.kind       = cbd_pkg::KIND_REJECT;
                                        n_pair.first.error_code = cbd_pkg::ERR_MALFORMED;
                                        n_pair.first.decoded_length = r_out_count;
                                        n_verdict_sent          = 1'b1;
                                    end else begin
                                        n_size_accum = {r_size_accum[SIZE_BITS-5:0], hex.val};
                                        n_digit_seen = 1'b1;
                                    end
                                end else if (!(r_in_byte == cbd_pkg::CH_SP && !r_digit_seen))
                                begin
                                    n_digits_closed = 1'b1;
                                end
                            end
                        end
                    end
                    PH_DATA: begin
                        push                      = 1'b1;
                        n_pair.first.kind         = cbd_pkg::KIND_PAYLOAD;
                        n_pair.first.payload_byte = r_in_byte;
                        if (r_out_count != 32'hFFFF_FFFF) begin
                            n_out_count = r_out_count + 32'd1;
                        end
                        n_bytes_left = r_bytes_left - SIZE_BITS'(1);
                        if (r_bytes_left == SIZE_BITS'(1)) begin
                            n_phase = PH_CR;
                        end
                    end
                    PH_CR: begin
                        if (r_in_byte == cbd_pkg::CH_CR) begin
                            n_phase = PH_LF;
                        end else begin
                            push                        = 1'b1;
                            n_pair.first.kind           = cbd_pkg::KIND_REJECT;
                            n_pair.first.error_code     = cbd_pkg::ERR_MALFORMED;
                            n_pair.first.decoded_length = r_out_count;
                            n_verdict_sent              = 1'b1;
                        end
                    end
                    PH_LF: begin
                        if (r_in_byte == cbd_pkg::CH_LF) begin
                            n_phase = PH_SIZE;
                        end else begin
                            push                        = 1'b1;
                            n_pair.first.kind           = cbd_pkg::KIND_REJECT;
                            n_pair.first.error_code     = cbd_pkg::ERR_MALFORMED;
                            n_pair.first.decoded_length = r_out_count;
                            n_verdict_sent              = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_SIZE;
                    end
                endcase
            end

            // body ended before any verdict
            if (!n_verdict_sent && r_in_eob) begin
                if (push) begin
                    n_pair.two                   = 1'b1;
                    n_pair.second.kind           = cbd_pkg::KIND_REJECT;
                    n_pair.second.error_code     = cbd_pkg::ERR_MALFORMED;
                    n_pair.second.decoded_length = n_out_count;
                end else begin
                    push                        = 1'b1;
                    n_pair.first.kind           = cbd_pkg::KIND_REJECT;
                    n_pair.first.error_code     = cbd_pkg::ERR_MALFORMED;
                    n_pair.first.decoded_length = n_out_count;
                end
                n_verdict_sent = 1'b1;
            end
        end

        // start of the next body
        if (r_in_eob) begin
            n_phase         = PH_SIZE;
            n_size_accum    = '0;
            n_bytes_left    = '0;
            n_raw_count     = '0;
            n_out_count     = '0;
            n_digit_seen    = 1'b0;
            n_digits_closed = 1'b0;
            n_cr_pending    = 1'b0;
            n_verdict_sent  = 1'b0;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SIZE;
            r_size_accum    <= '0;
            r_bytes_left    <= '0;
            r_raw_count     <= '0;
            r_out_count     <= '0;
            r_digit_seen    <= 1'b0;
            r_digits_closed <= 1'b0;
            r_cr_pending    <= 1'b0;
            r_verdict_sent  <= 1'b0;
        end else if (proc) begin
            r_phase         <= n_phase;
            r_size_accum    <= n_size_accum;
            r_bytes_left    <= n_bytes_left;
            r_raw_count     <= n_raw_count;
            r_out_count     <= n_out_count;
            r_digit_seen    <= n_digit_seen;
            r_digits_closed <= n_digits_closed;
            r_cr_pending    <= n_cr_pending;
            r_verdict_sent  <= n_verdict_sent;
        end
    end

    // result queue output side
    assign head_pair   = r_q[r_q_head];
    assign o_out_valid = (r_q_count != 2'd0);
    assign out_acc     = o_out_valid && !i_out_stall;

    always_comb begin
        if (r_q_sel) begin
            o_kind           = head_pair.second.kind;
            o_payload_byte   = head_pair.second.payload_byte;
            o_error_code     = head_pair.second.error_code;
            o_decoded_length = head_pair.second.decoded_length;
            o_run_end        = 1'b1;
        end else begin
            o_kind           = head_pair.first.kind;
            o_payload_byte   = head_pair.first.payload_byte;
            o_error_code     = head_pair.first.error_code;
            o_decoded_length = head_pair.first.decoded_length;
            o_run_end        = !head_pair.two;
        end
    end

    // result queue pointers and storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_head  <= 1'b0;
            r_q_tail  <= 1'b0;
            r_q_count <= 2'd0;
            r_q_sel   <= 1'b0;
        end else begin
            if (proc && push) begin
                r_q_tail <= !r_q_tail;
            end
            if (out_acc) begin
                if (!r_q_sel && head_pair.two) begin
                    r_q_sel <= 1'b1;
                end else begin
                    r_q_sel  <= 1'b0;
                    r_q_head <= !r_q_head;
                end
            end
            r_q_count <= r_q_count + 2'((proc && push) ? 1 : 0)
                       - 2'((out_acc && (r_q_sel || !head_pair.two)) ? 1 : 0);
        end
        if (proc && push) begin
            r_q[r_q_tail] <= n_pair;
        end
    end

endmodule

`default_nettype wire

>>> dv/chunked_body_decoder_checker.sv
`timescale 1ns / 1ps
// chunked_body_decoder_checker: watches the raw, result and limit channels of
// chunked_body_decoder_unit, predicts each result word and compares it.
// Depends on cbd_pkg for result kinds, error codes and framing characters.
module chunked_body_decoder_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [7:0]  i_raw_byte,
    input  wire         i_end_of_body,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [1:0]  i_kind,
    input  wire  [7:0]  i_payload_byte,
    input  wire  [1:0]  i_error_code,
    input  wire  [31:0] i_decoded_length,
    input  wire         i_run_end,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [1:0] {
        FRAME_SIZE_LINE,
        FRAME_DATA,
        FRAME_CR,
        FRAME_LF
    } t_frame_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [1:0]  error_code;
        logic [31:0] decoded_length;
        logic        run_end;
    } t_result_word;

    // decoder state as the block should hold it
    logic [31:0]  body_limit = cbd_pkg::MAX_BODY_RESET;
    t_frame_phase frame_phase = FRAME_SIZE_LINE;
    logic [31:0]  size_accum = '0;
    logic [31:0]  chunk_left = '0;
    logic [32:0]  raw_seen = '0;
    logic [31:0]  payload_seen = '0;
    logic         digit_seen = 1'b0;
    logic         digits_closed = 1'b0;
    logic         cr_pending = 1'b0;
    logic         verdict_sent = 1'b0;

    t_result_word awaited_words[$];
    int           step_words = 0;
    int           fail_total = 0;
    int           pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic restart_body();
        frame_phase   = FRAME_SIZE_LINE;
        size_accum    = '0;
        chunk_left    = '0;
        raw_seen      = '0;
        payload_seen  = '0;
        digit_seen    = 1'b0;
        digits_closed = 1'b0;
        cr_pending    = 1'b0;
        verdict_sent  = 1'b0;
    endtask

    task automatic emit_word(input logic [1:0] kind, input logic [7:0] data,
                             input logic [1:0] code, input logic [31:0] length);
        t_result_word w;
        w.kind           = kind;
        w.payload_byte   = data;
        w.error_code     = code;
        w.decoded_length = length;
        w.run_end        = 1'b0;
        awaited_words.insert(awaited_words.size(), w);
        step_words++;
    endtask

    task automatic reject_body(input logic [1:0] code);
        emit_word(cbd_pkg::KIND_REJECT, 8'h00, code, payload_seen);
        verdict_sent = 1'b1;
    endtask

    // one character of a size line that is not the closing lf
    task automatic take_size_char(input logic [7:0] b);
        logic [3:0] nib;
        logic       is_hex;
        is_hex = 1'b1;
        nib    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            nib = b[3:0];
        end else if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h66) begin
            nib = b[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
        cr_pending = (b == cbd_pkg::CH_CR);
        if (!digits_closed) begin
            if (is_hex) begin
                // a further digit would not fit in the size
                if (size_accum[31:28] != 4'd0) begin
                    reject_body(cbd_pkg::ERR_MALFORMED);
                end else begin
                    size_accum = {size_accum[27:0], nib};
                    digit_seen = 1'b1;
                end
            end else if (b != cbd_pkg::CH_SP || digit_seen) begin
                digits_closed = 1'b1;
            end
        end
    endtask

    task automatic decode_framing(input logic [7:0] b);
        case (frame_phase)
            FRAME_SIZE_LINE: begin
                if (cr_pending && b == cbd_pkg::CH_LF) begin
                    cr_pending = 1'b0;
                    if (!digit_seen) begin
                        reject_body(cbd_pkg::ERR_MALFORMED);
                    end else if (size_accum == '0) begin
                        emit_word(cbd_pkg::KIND_DONE, 8'h00, cbd_pkg::ERR_NONE, payload_seen);
                        verdict_sent = 1'b1;
                    end else begin
                        chunk_left    = size_accum;
                        frame_phase   = FRAME_DATA;
                        size_accum    = '0;
                        digit_seen    = 1'b0;
                        digits_closed = 1'b0;
                    end
                end else begin
                    take_size_char(b);
                end
            end
            FRAME_DATA: begin
                emit_word(cbd_pkg::KIND_PAYLOAD, b, cbd_pkg::ERR_NONE, 32'd0);
                if (payload_seen != 32'hFFFF_FFFF) payload_seen++;
                chunk_left--;
                if (chunk_left == '0) frame_phase = FRAME_CR;
            end
            FRAME_CR: begin
                if (b == cbd_pkg::CH_CR) frame_phase = FRAME_LF;
                else reject_body(cbd_pkg::ERR_MALFORMED);
            end
            default: begin
                if (b == cbd_pkg::CH_LF) frame_phase = FRAME_SIZE_LINE;
                else reject_body(cbd_pkg::ERR_MALFORMED);
            end
        endcase
    endtask

    // all result words caused by one raw word
    task automatic predict_raw_byte(input logic [7:0] b, input logic eob);
        step_words = 0;
        if (!verdict_sent) begin
            if (!raw_seen[32]) raw_seen++;
            if (raw_seen > {1'b0, body_limit}) reject_body(cbd_pkg::ERR_TOO_LARGE);
            else decode_framing(b);
            if (!verdict_sent && eob) reject_body(cbd_pkg::ERR_MALFORMED);
        end
        if (eob) restart_body();
        if (step_words > 0) begin
            awaited_words[awaited_words.size() - 1].run_end = 1'b1;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_total++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    // results first, then the limit and raw words of the same edge
    always @(posedge i_clk) begin : watch_channels
        t_result_word want;
        if (!i_rst_n) begin
            body_limit = cbd_pkg::MAX_BODY_RESET;
            restart_body();
            awaited_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_words.size() == 0) begin
                    fail_total++;
                    $error("result word with nothing expected: kind %0d, payload 0x%0h",
                           i_kind, i_payload_byte);
                end else begin
                    want = awaited_words.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_kind));
                    check_field("payload_byte", 32'(want.payload_byte), 32'(i_payload_byte));
                    check_field("error_code", 32'(want.error_code), 32'(i_error_code));
                    check_field("decoded_length", want.decoded_length, i_decoded_length);
                    check_field("run_end", 32'(want.run_end), 32'(i_run_end));
                end
            end
            if (i_cfg_valid && i_cfg_ready) body_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall) predict_raw_byte(i_raw_byte, i_end_of_body);
        end
        pending_total = awaited_words.size();
    end

endmodule

>>> dv/chunked_body_decoder_unit_tb.sv
`timescale 1ns / 1ps
// chunked_body_decoder_unit_tb: feeds directed and random chunked bodies and
// limit writes to chunked_body_decoder_unit and reports the verdict.
// Depends on cbd_pkg, the block and chunked_body_decoder_checker.
module chunked_body_decoder_unit_tb;

    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_raw_byte = 8'h00;
    logic        i_end_of_body = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = 32'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic [1:0]  o_error_code;
    logic [31:0] o_decoded_length;
    logic        o_run_end;
    logic        o_cfg_ready;

    int         fail_count;
    int         pending_words;
    int         sent_count = 0;
    int         quiet_cycles = 0;
    bit         tx_gaps = 1'b0;
    bit         rx_gaps = 1'b0;
    logic [7:0] raw_body[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    chunked_body_decoder_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_raw_byte       (i_raw_byte),
        .i_end_of_body    (i_end_of_body),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_error_code     (o_error_code),
        .o_decoded_length (o_decoded_length),
        .o_run_end        (o_run_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    chunked_body_decoder_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_raw_byte       (i_raw_byte),
        .i_end_of_body    (i_end_of_body),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_kind           (o_kind),
        .i_payload_byte   (o_payload_byte),
        .i_error_code     (o_error_code),
        .i_decoded_length (o_decoded_length),
        .i_run_end        (o_run_end),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words)
    );

    // receiver stalls in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_gaps && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one raw word, entered and left at a falling edge
    task automatic send_raw(input logic [7:0] b, input logic eob);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_raw_byte    <= b;
        i_end_of_body <= eob;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic ship_body();
        for (int k = 0; k < raw_body.size(); k++)
            send_raw(raw_body[k], k == raw_body.size() - 1);
        raw_body.delete();
    endtask

    // one more byte at the tail of the body being built
    task automatic add_byte(input logic [7:0] b);
        raw_body.insert(raw_body.size(), b);
    endtask

    task automatic append_text(input string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endtask

    task automatic append_crlf();
        add_byte(cbd_pkg::CH_CR);
        add_byte(cbd_pkg::CH_LF);
    endtask

    // framing characters, hex boundaries and arbitrary bytes
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 15))
            0:       return cbd_pkg::CH_CR;
            1:       return cbd_pkg::CH_LF;
            2:       return cbd_pkg::CH_SP;
            3:       return "0";
            4:       return "9";
            5:       return "a";
            6:       return "f";
            7:       return "A";
            8:       return "F";
            9:       return "g";
            10:      return "G";
            11:      return "/";
            12:      return ":";
            13:      return ";";
            default: return 8'($urandom);
        endcase
    endfunction

    // size line with random padding, case, leading zero and extension
    task automatic append_size_line(input int unsigned size);
        string      digits;
        logic [7:0] c;
        digits = $sformatf("%0h", size);
        if ($urandom_range(0, 3) == 0) digits = {"0", digits};
        repeat ($urandom_range(0, 2)) add_byte(cbd_pkg::CH_SP);
        for (int k = 0; k < digits.len(); k++) begin
            c = digits[k];
            if (c >= "a" && $urandom_range(0, 1) == 1) c = c - 8'h20;
            add_byte(c);
        end
        if ($urandom_range(0, 3) == 0) begin
            append_text(";x");
            if ($urandom_range(0, 1) == 1) add_byte(cbd_pkg::CH_CR);
            append_text("=1 ");
        end
        append_crlf();
    endtask

    // mostly well-formed bodies, some truncated or corrupted, some noise
    task automatic build_random_body();
        int unsigned style;
        int unsigned size;
        int unsigned cut;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(1, 10)) add_byte(noise_byte());
        end else begin
            repeat ($urandom_range(0, 3)) begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                append_size_line(size);
                repeat (size) add_byte(8'($urandom));
                append_crlf();
            end
            append_size_line(0);
            if ($urandom_range(0, 1) == 1) append_crlf();
            if (style <= 2) begin
                cut = $urandom_range(0, raw_body.size() - 1);
                if (style == 1) raw_body = raw_body[0:cut];
                else raw_body[cut] = noise_byte();
            end
        end
    endtask

    task automatic random_bodies_until(input int target);
        while (sent_count < target) begin
            build_random_body();
            ship_body();
        end
    endtask

    // hold the sender until every result is out and the block has settled
    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (pending_words == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // leading space, extreme data bytes, data not followed by cr
        append_text(" 1");
        append_crlf();
        add_byte(8'hFF);
        add_byte(8'h00);
        ship_body();
        // size that overflows on an upper-case digit
        append_text("1000000fF");
        ship_body();
        // body ends right after a data byte
        append_text("1");
        append_crlf();
        add_byte(8'h00);
        ship_body();
        // lone cr then no digits at all
        add_byte(cbd_pkg::CH_CR);
        append_text("q");
        append_crlf();
        ship_body();
        // empty body finished, then a byte that is ignored
        append_text("0");
        append_crlf();
        append_text("Z");
        ship_body();

        // zero limit rejects the first byte
        write_limit(32'd0);
        append_text("0");
        append_crlf();
        ship_body();
        append_text("7");
        ship_body();

        // limit hit inside a chunk
        write_limit(32'd3);
        append_text("1");
        append_crlf();
        append_text("A");
        ship_body();

        write_limit(32'hFFFF_FFFF);
        random_bodies_until(300);
        write_limit(32'($urandom_range(6, 48)));
        random_bodies_until(480);
        write_limit(cbd_pkg::MAX_BODY_RESET);
        random_bodies_until(600);

        // no idling in the last stretch
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_bodies_until(700);

        i_in_valid <= 1'b0;
        wait (pending_words == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
